// File: rtl/tcaf_pkg.sv
// Package for the two-class age-ordered FIFO: widths, defaults, codes and shared types.
// No dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package tcaf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SEQ_BITS_DEF    = 16;

    localparam int KIND_W    = 3;
    localparam int ID_W      = 32;
    localparam int STATUS_W  = 2;
    localparam int OUT_SEQ_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ0       = 3'd0,
        KIND_ENQ1       = 3'd1,
        KIND_DEQ0       = 3'd2,
        KIND_DEQ1       = 3'd3,
        KIND_DEQ_OLDEST = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // occupancy flags from one class queue to the top level
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// File: rtl/tcaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on tcaf_pkg only for a uniform import.
`timescale 1ns / 1ps

module tcaf_ram
    import tcaf_pkg::*;
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tcaf_queue.sv
// One class queue: head/tail/count control around a tcaf_ram instance.
// Depends on tcaf_pkg and tcaf_ram. Registered read data follows head pointer in the next cycle.
`timescale 1ns / 1ps

module tcaf_queue
    import tcaf_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int DATA_W = SEQ_BITS_DEF + ID_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output queue_stat_t       stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // push and pop are never raised together by the sequencer
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (pop) begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);

    tcaf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (push_data),
        .raddr (head_reg),
        .rdata (head_data)
    );

endmodule

// File: rtl/two_class_age_ordered_fifo.sv
// Top level of the two-class age-ordered FIFO: request sequencer, arrival counter, result register.
// Depends on tcaf_pkg and tcaf_queue (which holds tcaf_ram).
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid s_ready s_kind s_item_id        | in
//  result  | m_valid m_ready m_status m_out_id       | out
//          | m_out_class m_out_seq                   |
//
// Enqueues and unused kinds finish in the accept cycle; a stalled result holds off the next beat.
// Dequeues are accepted, then pass through a lookup state for the registered
// RAM read of the queue heads, where the oldest-head compare also happens.
// One request in flight; a new beat is taken while the last result is being taken.
// Reset (aresetn, synchronous) empties both queues and clears the arrival counter;
// the RAM contents are not cleared. A stalled result holds in its register.
`timescale 1ns / 1ps

module two_class_age_ordered_fifo
    import tcaf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [ID_W-1:0]      s_item_id,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [ID_W-1:0]      m_out_id,
    output logic                 m_out_class,
    output logic [OUT_SEQ_W-1:0] m_out_seq
);

    localparam int DATA_W = SEQ_BITS + ID_W;

    state_t                 state_reg, state_next;
    kind_t                  kind_reg, kind_next;
    logic [SEQ_BITS-1:0]    arrival_reg, arrival_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic                   out_class_reg, out_class_next;
    logic [OUT_SEQ_W-1:0]   out_seq_reg, out_seq_next;

    logic                   push0, push1, pop0, pop1;
    logic [DATA_W-1:0]      push_data;
    logic [DATA_W-1:0]      head0, head1;
    queue_stat_t            stat0, stat1;

    logic [SEQ_BITS-1:0]    seq0, seq1, seq_diff;
    logic                   take0, take1;
    logic                   accept;

    assign push_data = {arrival_reg, s_item_id};
    assign seq0      = head0[DATA_W-1 -: SEQ_BITS];
    assign seq1      = head1[DATA_W-1 -: SEQ_BITS];
    assign seq_diff  = seq1 - seq0;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_ENQ0;
            arrival_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            arrival_reg   <= arrival_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_class_reg  <= out_class_next;
        out_seq_reg    <= out_seq_next;
    end

    // dequeue selection in the lookup cycle
    always_comb begin
        take0 = 1'b0;
        take1 = 1'b0;
        unique case (kind_reg)
            KIND_DEQ0: take0 = !stat0.empty;
            KIND_DEQ1: take1 = !stat1.empty;
            KIND_DEQ_OLDEST: begin
                priority if (stat0.empty && stat1.empty) begin
                    take0 = 1'b0;
                end else if (stat1.empty) begin
                    take0 = 1'b1;
                end else if (stat0.empty) begin
                    take1 = 1'b1;
                end else begin
                    // class 1 older when (seq1 - seq0) is negative; ties go to class 0
                    take1 = seq_diff[SEQ_BITS-1];
                    take0 = !seq_diff[SEQ_BITS-1];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        arrival_next    = arrival_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_class_next  = out_class_reg;
        out_seq_next    = out_seq_reg;
        push0 = 1'b0;
        push1 = 1'b0;
        pop0  = 1'b0;
        pop1  = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind_t'(s_kind))
                        KIND_ENQ0, KIND_ENQ1: begin
                            out_valid_next = 1'b1;
                            out_id_next    = '0;
                            out_class_next = s_kind[0];
                            if ((s_kind[0] ? stat1.full : stat0.full)) begin
                                out_status_next = STATUS_FULL;
                                out_seq_next    = '0;
                            end else begin
                                push0           = !s_kind[0];
                                push1           = s_kind[0];
                                out_status_next = STATUS_OK;
                                out_seq_next    = OUT_SEQ_W'(arrival_reg);
                                arrival_next    = arrival_reg + 1'b1;
                            end
                        end
                        KIND_DEQ0, KIND_DEQ1, KIND_DEQ_OLDEST: begin
                            kind_next  = kind_t'(s_kind);
                            state_next = ST_LOOKUP;
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_EMPTY;
                            out_id_next     = '0;
                            out_class_next  = 1'b0;
                            out_seq_next    = '0;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                // head RAM data is valid now; result register is free
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                pop0           = take0;
                pop1           = take1;
                priority if (take0) begin
                    out_status_next = STATUS_OK;
                    out_id_next     = head0[ID_W-1:0];
                    out_class_next  = 1'b0;
                    out_seq_next    = OUT_SEQ_W'(seq0);
                end else if (take1) begin
                    out_status_next = STATUS_OK;
                    out_id_next     = head1[ID_W-1:0];
                    out_class_next  = 1'b1;
                    out_seq_next    = OUT_SEQ_W'(seq1);
                end else begin
                    out_status_next = STATUS_EMPTY;
                    out_id_next     = '0;
                    out_class_next  = 1'b0;
                    out_seq_next    = '0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    tcaf_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (DATA_W)
    ) u_queue0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push0),
        .push_data (push_data),
        .pop       (pop0),
        .head_data (head0),
        .stat      (stat0)
    );

    tcaf_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (DATA_W)
    ) u_queue1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push1),
        .push_data (push_data),
        .pop       (pop1),
        .head_data (head1),
        .stat      (stat1)
    );

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_out_id    = out_id_reg;
    assign m_out_class = out_class_reg;
    assign m_out_seq   = out_seq_reg;

endmodule
